// ===== sv/twhsm_pkg.sv =====
// ----------------------------------------------------------------------------
// twhsm_pkg: shared types and constants
// Action codes, sensor commands, start-pattern tables and conversion constants
// for the two-wire humidity sensor master.
// ----------------------------------------------------------------------------
package twhsm_pkg;

	// action codes
	localparam logic [1:0] ACT_TEMP     = 2'd0;
	localparam logic [1:0] ACT_HUM      = 2'd1;
	localparam logic [1:0] ACT_STATUS   = 2'd2;
	localparam logic [1:0] ACT_LINK_RST = 2'd3;

	// sensor command bytes
	localparam logic [7:0] CMD_TEMP   = 8'h03;
	localparam logic [7:0] CMD_HUM    = 8'h05;
	localparam logic [7:0] CMD_STATUS = 8'h06;

	// clock pulses sent with data released during a link reset
	localparam int RESET_PULSES = 10;

	// transmission start pattern, one bit per tick, tick 0 in bit 0
	localparam logic [8:0] START_DATA = 9'b110000011;
	localparam logic [8:0] START_CLK  = 9'b011000110;

	// conversion constants (hundredths)
	localparam logic [16:0] TEMP_OFFSET = 17'd4000;
	localparam logic [16:0] HUM_OFFSET  = 17'd400;
	localparam logic [15:0] RAW_CLAMP   = 16'd4095;
	localparam logic [20:0] HUM_LIN     = 21'd405;
	localparam logic [28:0] HUM_SQR     = 29'd28;

	// reciprocal division: n/100 = (n*RECIP_SMALL) >> SHIFT_SMALL, exact for n < 2**21;
	// n/100000 = (n*RECIP_LARGE) >> SHIFT_LARGE, exact for n < 2**29
	localparam int          DIV_W       = 29;
	localparam int          RECIP_W     = 30;
	localparam int          PROD_W      = 59;
	localparam int          SHIFT_SMALL = 28;
	localparam int          SHIFT_LARGE = 46;
	localparam logic [29:0] RECIP_SMALL = 30'd2684355;
	localparam logic [29:0] RECIP_LARGE = 30'd703687442;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_TEMP = 2'd1,
		KIND_HUM  = 2'd2
	} meas_kind_t;

	// result of one phase tick, before conversion
	typedef struct packed {
		logic        clock_level;
		logic        data_level;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  done_action;
		logic        ack_error;
		logic [15:0] raw_value;
		meas_kind_t  kind;
	} tick_res_t;

endpackage

// ===== sv/twhsm_div.sv =====
// ----------------------------------------------------------------------------
// twhsm_div: constant divider
// Floor division by 100 or 100000 through one shared reciprocal multiplier;
// the product of dividend and reciprocal is registered, and done flags the quotient.
// ----------------------------------------------------------------------------
module twhsm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        sel_large,
	input  logic [twhsm_pkg::DIV_W-1:0] dividend,
	output logic                        done,
	output logic [twhsm_pkg::DIV_W-1:0] quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic                           large_q;
	logic [twhsm_pkg::DIV_W-1:0]    dvd_q;
	logic [twhsm_pkg::PROD_W-1:0]   prod_q;
	logic [twhsm_pkg::RECIP_W-1:0]  recip;
	logic [twhsm_pkg::PROD_W-1:0]   prod_nx;
	logic [twhsm_pkg::PROD_W-1:0]   quo_full;

	always_comb begin
		recip    = large_q ? twhsm_pkg::RECIP_LARGE : twhsm_pkg::RECIP_SMALL;
		prod_nx  = twhsm_pkg::PROD_W'(dvd_q) * twhsm_pkg::PROD_W'(recip);
		quo_full = large_q ? (prod_q >> twhsm_pkg::SHIFT_LARGE) :
		                     (prod_q >> twhsm_pkg::SHIFT_SMALL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q   <= dividend;
			large_q <= sel_large;
		end
		if (busy_q) prod_q <= prod_nx;
	end

	assign done     = done_q;
	assign quotient = quo_full[twhsm_pkg::DIV_W-1:0];

endmodule

// ===== sv/twhsm_seq.sv =====
// ----------------------------------------------------------------------------
// twhsm_seq: two-wire bus sequencer
// Advances the bus sequence by one phase tick per step strobe and registers
// the line levels and status of that tick.
// ----------------------------------------------------------------------------
module twhsm_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic                  request,
	input  logic [1:0]            action,
	input  logic [7:0]            status_value,
	input  logic                  data_in,
	output twhsm_pkg::tick_res_t  res
);

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_RSTP   = 14'b00000000000010,
		ST_START  = 14'b00000000000100,
		ST_CMD    = 14'b00000000001000,
		ST_CMDACK = 14'b00000000010000,
		ST_WAIT   = 14'b00000000100000,
		ST_WDLY   = 14'b00000001000000,
		ST_RBIT   = 14'b00000010000000,
		ST_RACK1  = 14'b00000100000000,
		ST_RACK2  = 14'b00001000000000,
		ST_SSET   = 14'b00010000000000,
		ST_SHIGH  = 14'b00100000000000,
		ST_SLOW   = 14'b01000000000000,
		ST_SACK   = 14'b10000000000000
	} seq_state_t;

	seq_state_t step_q, e_step, n_step;
	logic [1:0]  pw_q, e_pw, n_pw;
	logic [3:0]  bc_q, e_bc, n_bc;
	logic [15:0] rx_q, e_rx, n_rx;
	logic [7:0]  send_q, e_send, n_send;
	logic [1:0]  act_q, e_act, n_act;
	logic        clk_q, n_clk;
	logic        dat_q, n_dat;
	logic        ack_q, e_ack, n_ack;
	logic        fin;
	logic        busy;
	logic [3:0]  st_idx;
	logic        cmd_bit;
	logic        stat_bit;
	logic [7:0]  stat_byte;
	twhsm_pkg::tick_res_t res_n;
	twhsm_pkg::tick_res_t res_q;

	always_comb begin
		// request taken only when idle
		e_step = step_q;
		e_pw   = pw_q;
		e_bc   = bc_q;
		e_rx   = rx_q;
		e_send = send_q;
		e_act  = act_q;
		e_ack  = ack_q;
		if (step_q == ST_IDLE && request) begin
			e_act  = action;
			e_send = (action == twhsm_pkg::ACT_TEMP) ? twhsm_pkg::CMD_TEMP :
			         (action == twhsm_pkg::ACT_HUM)  ? twhsm_pkg::CMD_HUM  :
			                                           twhsm_pkg::CMD_STATUS;
			e_rx   = (action == twhsm_pkg::ACT_STATUS) ? {8'd0, status_value} : 16'd0;
			e_ack  = 1'b0;
			e_bc   = 4'd0;
			e_pw   = 2'd0;
			e_step = (action == twhsm_pkg::ACT_LINK_RST) ? ST_RSTP : ST_START;
		end

		busy      = (e_step != ST_IDLE);
		st_idx    = (e_bc > 4'd8) ? 4'd8 : e_bc;
		cmd_bit   = e_send[3'd7 - e_bc[2:0]];
		stat_byte = e_rx[7:0];
		stat_bit  = stat_byte[3'd7 - e_bc[2:0]];

		n_step = e_step;
		n_pw   = e_pw;
		n_bc   = e_bc;
		n_rx   = e_rx;
		n_send = e_send;
		n_act  = e_act;
		n_ack  = e_ack;
		n_clk  = clk_q;
		n_dat  = dat_q;
		fin    = 1'b0;

		unique case (e_step)
			ST_IDLE: begin
				n_dat = 1'b1;
				n_clk = 1'b0;
			end
			ST_RSTP: begin
				n_dat = 1'b1;
				if (e_pw == 2'd0) begin
					n_clk = 1'b1;
					n_pw  = 2'd1;
				end else begin
					n_clk = 1'b0;
					n_pw  = 2'd0;
					if (({1'b0, e_bc} + 5'd1) >= 5'(twhsm_pkg::RESET_PULSES)) begin
						n_bc   = 4'd0;
						n_step = ST_START;
					end else begin
						n_bc = e_bc + 4'd1;
					end
				end
			end
			ST_START: begin
				n_dat = twhsm_pkg::START_DATA[st_idx];
				n_clk = twhsm_pkg::START_CLK[st_idx];
				if (st_idx < 4'd8) begin
					n_bc = st_idx + 4'd1;
				end else begin
					n_bc = 4'd0;
					n_pw = 2'd0;
					if (e_act == twhsm_pkg::ACT_LINK_RST) fin = 1'b1;
					else n_step = ST_CMD;
				end
			end
			ST_CMD: begin
				n_dat = cmd_bit;
				if (e_pw == 2'd0) begin
					n_clk = 1'b0;
					n_pw  = 2'd1;
				end else begin
					n_clk = 1'b1;
					n_pw  = 2'd0;
					if (e_bc[2:0] == 3'd7) begin
						n_bc   = 4'd0;
						n_step = ST_CMDACK;
					end else begin
						n_bc = {1'b0, e_bc[2:0] + 3'd1};
					end
				end
			end
			ST_CMDACK: begin
				n_dat = 1'b1;
				if (e_pw == 2'd0) begin
					n_clk = 1'b0;
					n_pw  = 2'd1;
				end else begin
					n_clk  = 1'b1;
					n_pw   = 2'd0;
					n_bc   = 4'd0;
					n_step = (e_act == twhsm_pkg::ACT_STATUS) ? ST_SSET : ST_WAIT;
				end
			end
			ST_WAIT: begin
				// no timeout: stays here until the sensor pulls data low
				n_dat = 1'b1;
				n_clk = 1'b0;
				if (!data_in) n_step = ST_WDLY;
			end
			ST_WDLY: begin
				n_dat  = 1'b1;
				n_clk  = 1'b0;
				n_rx   = 16'd0;
				n_bc   = 4'd0;
				n_pw   = 2'd0;
				n_step = ST_RBIT;
			end
			ST_RBIT: begin
				n_dat = 1'b1;
				if (e_pw == 2'd0) begin
					n_clk = 1'b1;
					n_rx  = {e_rx[14:0], data_in};
					n_pw  = 2'd1;
				end else begin
					n_clk = 1'b0;
					n_pw  = 2'd0;
					if (e_bc == 4'd7) n_step = ST_RACK1;
					else if (e_bc == 4'd15) n_step = ST_RACK2;
					else n_bc = e_bc + 4'd1;
				end
			end
			ST_RACK1, ST_RACK2: begin
				// ack the first byte, skip the checksum
				priority if (e_pw == 2'd0) begin
					n_dat = (e_step == ST_RACK2);
					n_clk = 1'b0;
					n_pw  = 2'd1;
				end else if (e_pw == 2'd1) begin
					n_dat = (e_step == ST_RACK2);
					n_clk = 1'b1;
					n_pw  = 2'd2;
				end else begin
					n_dat = 1'b1;
					n_clk = 1'b0;
					n_pw  = 2'd0;
					if (e_step == ST_RACK2) begin
						fin = 1'b1;
					end else begin
						n_bc   = 4'd8;
						n_step = ST_RBIT;
					end
				end
			end
			ST_SSET: begin
				n_dat  = stat_bit;
				n_clk  = 1'b0;
				n_pw   = 2'd0;
				n_step = ST_SHIGH;
			end
			ST_SHIGH: begin
				n_dat = stat_bit;
				n_clk = 1'b1;
				if (e_pw >= 2'd2) begin
					n_pw   = 2'd0;
					n_step = ST_SLOW;
				end else begin
					n_pw = e_pw + 2'd1;
				end
			end
			ST_SLOW: begin
				n_dat = stat_bit;
				n_clk = 1'b0;
				if (e_bc[2:0] == 3'd7) begin
					n_step = ST_SACK;
				end else begin
					n_bc   = {1'b0, e_bc[2:0] + 3'd1};
					n_step = ST_SSET;
				end
			end
			ST_SACK: begin
				n_dat = 1'b1;
				n_clk = 1'b1;
				n_ack = data_in;
				fin   = 1'b1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase

		if (fin) begin
			n_step = ST_IDLE;
			n_pw   = 2'd0;
			n_bc   = 4'd0;
		end

		res_n.clock_level = n_clk;
		res_n.data_level  = n_dat;
		res_n.busy_res    = busy;
		res_n.done_res    = fin;
		res_n.done_action = fin ? e_act : 2'd0;
		res_n.ack_error   = (fin && e_act == twhsm_pkg::ACT_STATUS) ? n_ack : 1'b0;
		res_n.raw_value   = (fin && (e_act == twhsm_pkg::ACT_TEMP ||
		                             e_act == twhsm_pkg::ACT_HUM)) ? n_rx : 16'd0;
		res_n.kind        = !fin                          ? twhsm_pkg::KIND_NONE :
		                    (e_act == twhsm_pkg::ACT_TEMP) ? twhsm_pkg::KIND_TEMP :
		                    (e_act == twhsm_pkg::ACT_HUM)  ? twhsm_pkg::KIND_HUM  :
		                                                     twhsm_pkg::KIND_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			pw_q   <= 2'd0;
			bc_q   <= 4'd0;
			rx_q   <= 16'd0;
			send_q <= 8'd0;
			act_q  <= 2'd0;
			clk_q  <= 1'b0;
			dat_q  <= 1'b1;
			ack_q  <= 1'b0;
		end else if (step_en) begin
			step_q <= n_step;
			pw_q   <= n_pw;
			bc_q   <= n_bc;
			rx_q   <= n_rx;
			send_q <= n_send;
			act_q  <= n_act;
			clk_q  <= n_clk;
			dat_q  <= n_dat;
			ack_q  <= n_ack;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) res_q <= res_n;
	end

	assign res = res_q;

endmodule

// ===== sv/two_wire_humidity_sensor_master_core.sv =====
// ----------------------------------------------------------------------------
// two_wire_humidity_sensor_master_core: two-wire humidity sensor master
// One input transaction per 2 us phase tick; each gives one result
// transaction with the bus line levels, status and converted measurement.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                                         tuser
//  s_axis   in   request, status_value, data_in (16 b)         action
//  m_axis   out  line levels, status, raw, measurement (40 b)  done_action
//
// Steps: an ordinary tick goes from the accept through C_CONV and C_EMIT back
//   to C_READY; the result register loads in C_EMIT. The tick that completes a
//   humidity measurement also passes C_DIVA and C_DIVB: the two quotients
//   (405*r/100 and 28*r*r/100000) go one after the other through a single
//   reciprocal multiplier.
// s_axis_tready is high only between ticks; a finished result waits in the
//   output register while the next tick is accepted and worked on.
// Reset: arst_n clears the bus sequence to idle (clock low, data released)
//   and empties the output register.
// Stalls: m_axis_tready low holds the result; a second result then waits
//   in the final step until the register frees up.
// ----------------------------------------------------------------------------
module two_wire_humidity_sensor_master_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] request, [8:1] status_value, [9] data_in, [15:10] zero
	input  logic [15:0] s_axis_tdata,
	// [1:0] action
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] clock_level, [1] data_level, [2] busy_res, [3] done_res,
	// [4] ack_error, [20:5] raw_value, [37:21] measurement_x100, [39:38] zero
	output logic [39:0] m_axis_tdata,
	// [1:0] done_action
	output logic [1:0]  m_axis_tuser
);

	typedef enum logic [4:0] {
		C_READY = 5'b00001,
		C_CONV  = 5'b00010,
		C_DIVA  = 5'b00100,
		C_DIVB  = 5'b01000,
		C_EMIT  = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q;

	logic                        s_acc;
	twhsm_pkg::tick_res_t        res;
	logic [11:0]                 hum_r;
	logic [23:0]                 sq_q;
	logic [14:0]                 q1_q;
	logic signed [16:0]          meas_q;
	logic                        div_start;
	logic                        div_large;
	logic [twhsm_pkg::DIV_W-1:0] div_dvd;
	logic                        div_done;
	logic [twhsm_pkg::DIV_W-1:0] div_quo;
	logic [20:0]                 lin_term;
	logic [28:0]                 sqr_term;
	logic                        emit;
	logic                        m_valid_q;
	logic [39:0]                 m_data_q;
	logic [1:0]                  m_user_q;

	assign s_axis_tready = (state_q == C_READY);
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	// bus sequencer advances one phase tick per accepted transaction
	twhsm_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (s_acc),
		.request      (s_axis_tdata[0]),
		.action       (s_axis_tuser),
		.status_value (s_axis_tdata[8:1]),
		.data_in      (s_axis_tdata[9]),
		.res          (res)
	);

	// humidity input saturated to 12 bits
	assign hum_r    = (res.raw_value > twhsm_pkg::RAW_CLAMP) ? 12'hFFF : res.raw_value[11:0];
	assign lin_term = 21'(hum_r) * twhsm_pkg::HUM_LIN;
	assign sqr_term = 29'(sq_q) * twhsm_pkg::HUM_SQR;

	// first pass: linear term / 100, second pass: square term / 100000
	assign div_start = ((state_q == C_CONV) && (res.kind == twhsm_pkg::KIND_HUM)) ||
	                   ((state_q == C_DIVA) && div_done);
	assign div_large = (state_q == C_DIVA);
	assign div_dvd   = (state_q == C_CONV) ? twhsm_pkg::DIV_W'(lin_term) : sqr_term;

	twhsm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.sel_large (div_large),
		.dividend  (div_dvd),
		.done      (div_done),
		.quotient  (div_quo)
	);

	assign emit = (state_q == C_EMIT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= C_READY;
			m_valid_q <= 1'b0;
		end else begin
			if (emit) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;

			unique case (state_q)
				C_READY: if (s_acc) state_q <= C_CONV;
				C_CONV: begin
					if (res.kind == twhsm_pkg::KIND_HUM) state_q <= C_DIVA;
					else state_q <= C_EMIT;
				end
				C_DIVA:  if (div_done) state_q <= C_DIVB;
				C_DIVB:  if (div_done) state_q <= C_EMIT;
				C_EMIT:  if (emit) state_q <= C_READY;
				default: state_q <= C_READY;
			endcase
		end
	end

	// conversion datapath and result register
	always_ff @(posedge clk) begin
		if (state_q == C_CONV) begin
			sq_q <= 24'(hum_r) * 24'(hum_r);
			unique case (res.kind)
				twhsm_pkg::KIND_TEMP: meas_q <= $signed({1'b0, res.raw_value} -
				                                        twhsm_pkg::TEMP_OFFSET);
				twhsm_pkg::KIND_HUM:  meas_q <= '0;
				default:              meas_q <= '0;
			endcase
		end
		if (state_q == C_DIVA && div_done) q1_q <= div_quo[14:0];
		if (state_q == C_DIVB && div_done) begin
			meas_q <= $signed({2'b00, q1_q} - {4'b0000, div_quo[12:0]} -
			                  twhsm_pkg::HUM_OFFSET);
		end
		if (emit) begin
			m_data_q <= {2'b00, meas_q, res.raw_value, res.ack_error, res.done_res,
			             res.busy_res, res.data_level, res.clock_level};
			m_user_q <= res.done_action;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
	// one tick at a time: no accept on the cycle after an accept
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("input accepted while previous tick in progress");

	// a completion is always reported inside a busy tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[3] || m_axis_tdata[2]))
		else $error("done without busy");

	// idle ticks leave the bus released with clock low
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[2]) |-> (!m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("bus driven while idle");

	// completed action reported only on a done tick
	a_done_action: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[3]) |-> (m_axis_tuser == 2'd0))
		else $error("done_action set without done");

	// divider results only arrive while a humidity conversion waits for them
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == C_DIVA) || (state_q == C_DIVB)))
		else $error("stray divider completion");
`endif

endmodule

// ===== tb/tb_two_wire_humidity_sensor_master_core.sv =====
// ----------------------------------------------------------------------------
// tb_two_wire_humidity_sensor_master_core: self-checking bench
// Each input transaction is one phase tick of the bus. A sensor responder
// answers the master tick by tick, and a cycle-free model predicts every
// result transaction, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_two_wire_humidity_sensor_master_core;

	// clock, reset and stream signals; every DUT input starts at a known level
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	localparam int RAND_TICKS  = 240;  // ticks in the random part
	localparam int HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int TAIL_CYCLES = 200;  // quiet time after the last result
	localparam int BUSY_REQ_PCT = 20;  // requests thrown in while busy

	// one result transaction, as the model sees it
	typedef struct packed {
		logic        clock_level;
		logic        data_level;
		logic        busy;
		logic        done;
		logic [1:0]  done_action;
		logic        ack_error;
		logic [15:0] raw;
		logic [16:0] meas;
	} bus_tick_t;

	localparam bus_tick_t IDLE_TICK = '{1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 17'd0};

	// one action and the way the sensor answers it
	typedef struct {
		logic [1:0]  act;
		logic [7:0]  status;
		logic [15:0] raw;         // word the sensor returns
		logic        ack;         // data level on the status acknowledge clock
		int          wait_ticks;  // ticks the sensor keeps data high before answering
		int          lead_idle;   // idle ticks before the request
		logic        typed;       // done fields below replace the model's
		logic [15:0] x_raw;
		logic [16:0] x_meas;
		logic        x_aerr;
	} plan_row_t;

	// sequencer steps of the model
	typedef enum logic [3:0] {
		SQ_IDLE, SQ_RST_PULSE, SQ_START, SQ_CMD, SQ_CMD_ACK, SQ_WAIT, SQ_WAIT_DLY,
		SQ_RD_BIT, SQ_RD_ACK1, SQ_RD_ACK2, SQ_ST_SET, SQ_ST_HIGH, SQ_ST_LOW, SQ_ST_ACK
	} sq_step_t;

	// directed cases: extremes of the raw word, humidity clamp, status acknowledge,
	// a sensor that keeps the line high for a long time, a link reset
	plan_row_t dir_plan [0:8] = '{
		'{twhsm_pkg::ACT_LINK_RST, 8'h00, 16'h0000, 1'b0,  0, 4,
			1'b1, 16'h0000, 17'd0, 1'b0},
		'{twhsm_pkg::ACT_TEMP,     8'h00, 16'h0000, 1'b0,  2, 1,
			1'b1, 16'h0000, -17'sd4000, 1'b0},
		'{twhsm_pkg::ACT_TEMP,     8'h00, 16'hFFFF, 1'b0,  0, 0,
			1'b1, 16'hFFFF, 17'd61535, 1'b0},
		'{twhsm_pkg::ACT_HUM,      8'h00, 16'h0000, 1'b0,  0, 0,
			1'b1, 16'h0000, -17'sd400, 1'b0},
		'{twhsm_pkg::ACT_HUM,      8'h00, 16'hFFFF, 1'b0,  3, 1,
			1'b1, 16'hFFFF, 17'd11489, 1'b0},
		'{twhsm_pkg::ACT_HUM,      8'h00, 16'd4096, 1'b0,  0, 0,
			1'b1, 16'd4096, 17'd11489, 1'b0},
		'{twhsm_pkg::ACT_STATUS,   8'hFF, 16'h0000, 1'b1,  0, 0,
			1'b1, 16'h0000, 17'd0, 1'b1},
		'{twhsm_pkg::ACT_STATUS,   8'hA5, 16'h0000, 1'b1,  0, 2,
			1'b0, 16'h0000, 17'd0, 1'b0},
		'{twhsm_pkg::ACT_TEMP,     8'h00, 16'h5AA5, 1'b0, 30, 0,
			1'b0, 16'h0000, 17'd0, 1'b0}
	};

	// bus model state, reset values
	sq_step_t    sq_step  = SQ_IDLE;
	logic [1:0]  sq_phase = '0;
	logic [3:0]  sq_bits  = '0;
	logic [15:0] sq_shift = '0;
	logic [7:0]  sq_cmd   = '0;
	logic [1:0]  sq_act   = '0;
	logic        line_clk = 1'b0;
	logic        line_dat = 1'b1;
	logic        sq_ack   = 1'b0;

	bus_tick_t   bus_tick_q [$];   // predicted results not yet seen
	plan_row_t   job;              // action in progress on the sender side
	int          wait_left;
	int          n_ticks = 0;
	int          n_checked = 0;
	int          mismatches = 0;
	int          job_count [4] = '{0, 0, 0, 0};
	logic        quiet = 1'b0;     // no random idling on either side
	logic        hold_ask = 1'b0;  // asks the receiver for one long hold-off

	two_wire_humidity_sensor_master_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// bus model
	// ------------------------------------------------------------------
	function automatic void drive_lines(logic d, logic c);
		line_dat = d;
		line_clk = c;
	endfunction

	// hundredths of a degree (raw - 4000) or of a percent (clamped quadratic)
	function automatic logic [16:0] to_hundredths(logic [1:0] act, logic [15:0] raw);
		int r;
		if (act == twhsm_pkg::ACT_TEMP)
			return {1'b0, raw} - 17'd4000;
		r = (raw > 16'd4095) ? 4095 : int'(raw);
		return 17'((405 * r) / 100 - (28 * r * r) / 100000 - 400);
	endfunction

	// one tick of a running sequence; 1 on its last tick
	function automatic logic advance_sequence(logic din);
		logic b;
		case (sq_step)
			SQ_RST_PULSE: begin
				if (sq_phase == 2'd0) begin
					drive_lines(1'b1, 1'b1);
					sq_phase = 2'd1;
				end else begin
					drive_lines(1'b1, 1'b0);
					sq_phase = 2'd0;
					if (int'(sq_bits) + 1 >= twhsm_pkg::RESET_PULSES) begin
						sq_bits = '0;
						sq_step = SQ_START;
					end else
						sq_bits = sq_bits + 4'd1;
				end
				return 1'b0;
			end
			SQ_START: begin
				if (sq_bits > 4'd8) sq_bits = 4'd8;
				drive_lines(twhsm_pkg::START_DATA[sq_bits], twhsm_pkg::START_CLK[sq_bits]);
				if (sq_bits < 4'd8) begin
					sq_bits = sq_bits + 4'd1;
					return 1'b0;
				end
				sq_bits = '0;
				sq_phase = '0;
				if (sq_act == twhsm_pkg::ACT_LINK_RST) return 1'b1;
				sq_step = SQ_CMD;
				return 1'b0;
			end
			SQ_CMD: begin
				b = sq_cmd[3'd7 - sq_bits[2:0]];
				if (sq_phase == 2'd0) begin
					drive_lines(b, 1'b0);
					sq_phase = 2'd1;
					return 1'b0;
				end
				drive_lines(b, 1'b1);
				sq_phase = '0;
				if (sq_bits[2:0] == 3'd7) begin
					sq_bits = '0;
					sq_step = SQ_CMD_ACK;
				end else
					sq_bits = {1'b0, sq_bits[2:0] + 3'd1};
				return 1'b0;
			end
			SQ_CMD_ACK: begin
				if (sq_phase == 2'd0) begin
					drive_lines(1'b1, 1'b0);
					sq_phase = 2'd1;
					return 1'b0;
				end
				drive_lines(1'b1, 1'b1);
				sq_phase = '0;
				sq_bits = '0;
				sq_step = (sq_act == twhsm_pkg::ACT_STATUS) ? SQ_ST_SET : SQ_WAIT;
				return 1'b0;
			end
			SQ_WAIT: begin
				drive_lines(1'b1, 1'b0);
				if (!din) sq_step = SQ_WAIT_DLY;
				return 1'b0;
			end
			SQ_WAIT_DLY: begin
				drive_lines(1'b1, 1'b0);
				sq_shift = '0;
				sq_bits = '0;
				sq_phase = '0;
				sq_step = SQ_RD_BIT;
				return 1'b0;
			end
			SQ_RD_BIT: begin
				if (sq_phase == 2'd0) begin
					drive_lines(1'b1, 1'b1);
					sq_shift = {sq_shift[14:0], din};
					sq_phase = 2'd1;
					return 1'b0;
				end
				drive_lines(1'b1, 1'b0);
				sq_phase = '0;
				if (sq_bits == 4'd7) sq_step = SQ_RD_ACK1;
				else if (sq_bits >= 4'd15) sq_step = SQ_RD_ACK2;
				else sq_bits = sq_bits + 4'd1;
				return 1'b0;
			end
			SQ_RD_ACK1, SQ_RD_ACK2: begin
				// master pulls data low after the first byte, releases it after the second
				b = (sq_step == SQ_RD_ACK2);
				if (sq_phase == 2'd0) begin
					drive_lines(b, 1'b0);
					sq_phase = 2'd1;
					return 1'b0;
				end
				if (sq_phase == 2'd1) begin
					drive_lines(b, 1'b1);
					sq_phase = 2'd2;
					return 1'b0;
				end
				drive_lines(1'b1, 1'b0);
				sq_phase = '0;
				if (sq_step == SQ_RD_ACK2) return 1'b1;
				sq_bits = 4'd8;
				sq_step = SQ_RD_BIT;
				return 1'b0;
			end
			SQ_ST_SET, SQ_ST_HIGH, SQ_ST_LOW: begin
				b = sq_shift[3'd7 - sq_bits[2:0]];
				if (sq_step == SQ_ST_SET) begin
					drive_lines(b, 1'b0);
					sq_phase = '0;
					sq_step = SQ_ST_HIGH;
				end else if (sq_step == SQ_ST_HIGH) begin
					drive_lines(b, 1'b1);
					if (sq_phase >= 2'd2) begin
						sq_phase = '0;
						sq_step = SQ_ST_LOW;
					end else
						sq_phase = sq_phase + 2'd1;
				end else begin
					drive_lines(b, 1'b0);
					if (sq_bits[2:0] == 3'd7)
						sq_step = SQ_ST_ACK;
					else begin
						sq_bits = {1'b0, sq_bits[2:0] + 3'd1};
						sq_step = SQ_ST_SET;
					end
				end
				return 1'b0;
			end
			SQ_ST_ACK: begin
				drive_lines(1'b1, 1'b1);
				sq_ack = din;
				return 1'b1;
			end
			default: return 1'b1;
		endcase
	endfunction

	function automatic bus_tick_t predict_bus_tick(logic req, logic [1:0] act,
			logic [7:0] sv, logic din);
		bus_tick_t t;
		t = '0;
		// requests only count while idle
		if (sq_step == SQ_IDLE && req) begin
			sq_act = act;
			case (act)
				twhsm_pkg::ACT_TEMP: sq_cmd = twhsm_pkg::CMD_TEMP;
				twhsm_pkg::ACT_HUM:  sq_cmd = twhsm_pkg::CMD_HUM;
				default:             sq_cmd = twhsm_pkg::CMD_STATUS;
			endcase
			sq_shift = (act == twhsm_pkg::ACT_STATUS) ? {8'd0, sv} : 16'd0;
			sq_ack = 1'b0;
			sq_bits = '0;
			sq_phase = '0;
			sq_step = (act == twhsm_pkg::ACT_LINK_RST) ? SQ_RST_PULSE : SQ_START;
		end
		if (sq_step == SQ_IDLE)
			drive_lines(1'b1, 1'b0);
		else begin
			t.busy = 1'b1;
			if (advance_sequence(din)) begin
				t.done = 1'b1;
				t.done_action = sq_act;
				if (sq_act == twhsm_pkg::ACT_STATUS)
					t.ack_error = sq_ack;
				else if (sq_act != twhsm_pkg::ACT_LINK_RST) begin
					t.raw = sq_shift;
					t.meas = to_hundredths(sq_act, sq_shift);
				end
				sq_step = SQ_IDLE;
				sq_phase = '0;
				sq_bits = '0;
			end
		end
		t.clock_level = line_clk;
		t.data_level = line_dat;
		return t;
	endfunction

	// ------------------------------------------------------------------
	// sensor side: answers from the model's step, noise where data is ignored
	// ------------------------------------------------------------------
	function automatic logic sensor_reply();
		case (sq_step)
			SQ_WAIT: begin
				if (wait_left > 0) begin
					wait_left--;
					return 1'b1;
				end
				return 1'b0;
			end
			SQ_RD_BIT: if (sq_phase == 2'd0) return job.raw[4'd15 - sq_bits];
			SQ_ST_ACK: return job.ack;
			default: ;
		endcase
		return 1'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	// one tick transaction; start marks the request that opens the job
	task automatic send_tick(input logic start);
		logic       req;
		logic [1:0] act;
		logic [7:0] sv;
		logic       din;
		bus_tick_t  want;
		req = start || (sq_step != SQ_IDLE && $urandom_range(99) < BUSY_REQ_PCT);
		act = start ? job.act : 2'($urandom);
		sv  = start ? job.status : 8'($urandom);
		din = sensor_reply();
		want = predict_bus_tick(req, act, sv, din);
		if (job.typed) begin
			if (!want.busy)
				want = IDLE_TICK;
			else if (want.done) begin
				want.done_action = job.act;
				want.ack_error = job.x_aerr;
				want.raw = job.x_raw;
				want.meas = job.x_meas;
			end
		end
		if (!quiet && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tdata  <= {6'd0, din, sv, req};
		s_axis_tuser  <= act;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		bus_tick_q.push_back(want);
		n_ticks++;
	endtask

	// idle ticks, the request, then ticks until the sequence finishes
	task automatic run_job();
		wait_left = job.wait_ticks;
		job_count[job.act]++;
		repeat (job.lead_idle) send_tick(1'b0);
		send_tick(1'b1);
		while (sq_step != SQ_IDLE) send_tick(1'b0);
	endtask

	// sender stops offering until every predicted result has come back
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (bus_tick_q.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// receiver: random stalls, one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= quiet || ($urandom_range(99) >= 6);
		end
	end

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void field_check(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
					n_checked, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		bus_tick_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (bus_tick_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result transaction with nothing predicted: tdata 0x%0h",
						m_axis_tdata);
			end else begin
				want = bus_tick_q.pop_front();
				field_check("clock_level", 32'(want.clock_level), 32'(m_axis_tdata[0]));
				field_check("data_level", 32'(want.data_level), 32'(m_axis_tdata[1]));
				field_check("busy_res", 32'(want.busy), 32'(m_axis_tdata[2]));
				field_check("done_res", 32'(want.done), 32'(m_axis_tdata[3]));
				field_check("ack_error", 32'(want.ack_error), 32'(m_axis_tdata[4]));
				field_check("raw_value", 32'(want.raw), 32'(m_axis_tdata[20:5]));
				field_check("measurement_x100", 32'(want.meas), 32'(m_axis_tdata[37:21]));
				field_check("done_action", 32'(want.done_action), 32'(m_axis_tuser));
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int jobs_done;
		int rand_start;
		jobs_done = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases, then a pause until the pipe is empty
		foreach (dir_plan[i]) begin
			job = dir_plan[i];
			run_job();
		end
		wait_for_results();

		// random actions; the middle stretch runs without idling
		rand_start = n_ticks;
		while (n_ticks - rand_start < RAND_TICKS) begin
			quiet = (n_ticks - rand_start >= 80) && (n_ticks - rand_start < 180);
			job.act = 2'($urandom_range(3));
			job.status = 8'($urandom);
			case ($urandom_range(7))
				0: job.raw = 16'h0000;
				1: job.raw = 16'hFFFF;
				2: job.raw = 16'd4095 + 16'($urandom_range(1));
				3, 4: job.raw = 16'($urandom_range(4095));
				default: job.raw = 16'($urandom);
			endcase
			job.ack = 1'($urandom);
			job.wait_ticks = ($urandom_range(9) == 0) ? int'($urandom_range(20, 40))
				: int'($urandom_range(4));
			job.lead_idle = int'($urandom_range(3));
			job.typed = 1'b0;
			// long receiver hold-off while the sender keeps pushing ticks
			if (jobs_done == 1) hold_ask = 1'b1;
			run_job();
			jobs_done++;
			if ($urandom_range(7) == 0) wait_for_results();
		end
		quiet = 1'b0;
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d bus ticks: %0d temperature, %0d humidity,",
			n_ticks, job_count[twhsm_pkg::ACT_TEMP], job_count[twhsm_pkg::ACT_HUM]);
		$display("  %0d status writes, %0d link resets; %0d results compared, %0d left",
			job_count[twhsm_pkg::ACT_STATUS], job_count[twhsm_pkg::ACT_LINK_RST],
			n_checked, bus_tick_q.size());
		if (mismatches == 0 && bus_tick_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
